/* hdl/sis_pkg.sv */
package sis_pkg;

    // fixed field widths and default key capacity
    localparam int KEY_W        = 64;
    localparam int POSITION_W   = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 2;
    localparam int DEF_MAX_KEYS = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ASCENDING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;

    // key width codes
    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } width_code_t;

    // comparison mode in force
    typedef struct packed {
        logic        ascending;
        logic        keys_signed;
        width_code_t width_code;
    } cfg_t;

    // per-cell move selection
    typedef enum logic [2:0] {
        OP_HOLD     = 3'd0,
        OP_SHIFT_UP = 3'd1,
        OP_SHIFT_DN = 3'd2,
        OP_TAKE_UP  = 3'd3,
        OP_TAKE_DN  = 3'd4
    } op_t;

endpackage

/* hdl/sis_cmp.sv */
module sis_cmp #(
    parameter int PosW = 6
) (
    input  sis_pkg::cfg_t                cfg,
    input  logic                         lo_valid,
    input  logic [sis_pkg::KEY_W-1:0]    lo_key,
    input  logic [PosW-1:0]              lo_pos,
    input  logic                         hi_valid,
    input  logic [sis_pkg::KEY_W-1:0]    hi_key,
    input  logic [PosW-1:0]              hi_pos,
    output logic                         swap
);
    import sis_pkg::*;

    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] sign;
    logic [KEY_W-1:0] lo_val;
    logic [KEY_W-1:0] hi_val;
    logic             lo_after;

    // mask and sign bit for the configured width
    always_comb
    begin
        unique case (cfg.width_code)
            WIDTH_8:
            begin
                mask = 64'h0000_0000_0000_00FF;
                sign = 64'h0000_0000_0000_0080;
            end
            WIDTH_16:
            begin
                mask = 64'h0000_0000_0000_FFFF;
                sign = 64'h0000_0000_0000_8000;
            end
            WIDTH_32:
            begin
                mask = 64'h0000_0000_FFFF_FFFF;
                sign = 64'h0000_0000_8000_0000;
            end
            default:
            begin
                mask = 64'hFFFF_FFFF_FFFF_FFFF;
                sign = 64'h8000_0000_0000_0000;
            end
        endcase
    end

    // map keys to unsigned order values
    assign lo_val = (lo_key & mask) ^ (cfg.keys_signed ? sign : '0);
    assign hi_val = (hi_key & mask) ^ (cfg.keys_signed ? sign : '0);

    // lower entry belongs after upper one, ties broken by arrival position
    always_comb
    begin
        if (lo_val != hi_val)
            lo_after = cfg.ascending ? (lo_val > hi_val) : (lo_val < hi_val);
        else
            lo_after = lo_pos > hi_pos;
    end

    assign swap = lo_valid && hi_valid && lo_after;

endmodule

/* hdl/sis_cell.sv */
module sis_cell #(
    parameter int PosW = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sis_pkg::op_t                 op,
    input  logic                         dn_valid,
    input  logic [sis_pkg::KEY_W-1:0]    dn_key,
    input  logic [PosW-1:0]              dn_pos,
    input  logic                         up_valid,
    input  logic [sis_pkg::KEY_W-1:0]    up_key,
    input  logic [PosW-1:0]              up_pos,
    output logic                         valid,
    output logic [sis_pkg::KEY_W-1:0]    key,
    output logic [PosW-1:0]              pos
);
    import sis_pkg::*;

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PosW-1:0]  pos_reg, pos_next;

    // take from the lower or upper neighbor, or keep
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        unique case (op) inside
            OP_SHIFT_UP, OP_TAKE_DN:
            begin
                valid_next = dn_valid;
                key_next   = dn_key;
                pos_next   = dn_pos;
            end
            OP_SHIFT_DN, OP_TAKE_UP:
            begin
                valid_next = up_valid;
                key_next   = up_key;
                pos_next   = up_pos;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // key and position payload
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign pos   = pos_reg;

endmodule

/* hdl/stable_index_sort.sv */
// A set of keys loads at one key per cycle through cell 0, then odd-even exchange
// rounds along the cell chain sort it, then one result per cycle leaves while
// m_tready is high. A new set is not taken until the last result of a set has left,
// since the chain with its single load and unload port at cell 0 holds one set.
// Reset (rst_n, asynchronous, active low) empties the chain, clears the key
// count and overflow flag and loads the default configuration.
module stable_index_sort #(
    parameter int MAX_KEYS = sis_pkg::DEF_MAX_KEYS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // key_bits[63:0]
    input  logic                             s_tlast,   // last_key
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // position[5:0], zero fill
    output logic                             m_tlast,   // last_rank
    output logic [0:0]                       m_tuser,   // overflow
    input  logic                             cfg_we,
    input  logic [sis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sis_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sis_pkg::*;

    localparam int PosW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CntW = $clog2(MAX_KEYS + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_KEYS);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_SORT  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] round_reg, round_next;
    logic            ovf_reg, ovf_next;
    cfg_t            cfg_reg, cfg_next;

    logic s_req;
    logic m_req;
    logic store_key;

    logic             cell_valid [MAX_KEYS];
    logic [KEY_W-1:0] cell_key   [MAX_KEYS];
    logic [PosW-1:0]  cell_pos   [MAX_KEYS];
    op_t              cell_op    [MAX_KEYS];
    logic             swap       [MAX_KEYS-1];

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_req     = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_DRAIN);
    assign m_req     = m_tvalid && m_tready;
    assign store_key = s_req && (count_reg < MaxCnt);

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ASCENDING: cfg_next.ascending   = cfg_data[0];
                CFG_SIGNED:    cfg_next.keys_signed = cfg_data[0];
                CFG_WIDTH:     cfg_next.width_code  = width_code_t'(cfg_data[1:0]);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // sequencer: load, exchange rounds, unload
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_req)
                begin
                    if (store_key)
                        count_next = count_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = ST_SORT;
                        round_next = '0;
                    end
                end
            end
            ST_SORT:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == count_reg - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (m_req && m_tlast)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            round_reg <= '0;
            ovf_reg   <= 1'b0;
            cfg_reg   <= '{ascending: 1'b1, keys_signed: 1'b1, width_code: WIDTH_64};
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            ovf_reg   <= ovf_next;
            cfg_reg   <= cfg_next;
        end
    end

    // one comparator per neighbor pair
    for (genvar p = 0; p < MAX_KEYS - 1; p++)
    begin : g_pair
        sis_cmp #(.PosW(PosW)) u_cmp (
            .cfg      (cfg_reg),
            .lo_valid (cell_valid[p]),
            .lo_key   (cell_key[p]),
            .lo_pos   (cell_pos[p]),
            .hi_valid (cell_valid[p+1]),
            .hi_key   (cell_key[p+1]),
            .hi_pos   (cell_pos[p+1]),
            .swap     (swap[p])
        );
    end

    // the cell chain
    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_cell
        localparam logic ParityBit = 1'(i % 2);

        logic             dn_valid;
        logic [KEY_W-1:0] dn_key;
        logic [PosW-1:0]  dn_pos;
        logic             up_valid;
        logic [KEY_W-1:0] up_key;
        logic [PosW-1:0]  up_pos;
        logic             take_up;
        logic             take_dn;

        // lower neighbor, the input stream at cell 0
        if (i == 0)
        begin : g_bottom
            assign dn_valid = 1'b1;
            assign dn_key   = s_tdata;
            assign dn_pos   = count_reg[PosW-1:0];
            assign take_dn  = 1'b0;
        end
        else
        begin : g_lower
            assign dn_valid = cell_valid[i-1];
            assign dn_key   = cell_key[i-1];
            assign dn_pos   = cell_pos[i-1];
            assign take_dn  = swap[i-1];
        end

        // upper neighbor, empty past the top cell
        if (i == MAX_KEYS - 1)
        begin : g_top
            assign up_valid = 1'b0;
            assign up_key   = '0;
            assign up_pos   = '0;
            assign take_up  = 1'b0;
        end
        else
        begin : g_upper
            assign up_valid = cell_valid[i+1];
            assign up_key   = cell_key[i+1];
            assign up_pos   = cell_pos[i+1];
            assign take_up  = swap[i];
        end

        // per-cell move: shift on load and unload; while sorting, lower of a pair when its parity matches the round
        always_comb
        begin
            cell_op[i] = OP_HOLD;
            if (store_key)
                cell_op[i] = OP_SHIFT_UP;
            else if (m_req)
                cell_op[i] = OP_SHIFT_DN;
            else if (state_reg == ST_SORT)
            begin
                if (round_reg[0] == ParityBit)
                    cell_op[i] = take_up ? OP_TAKE_UP : OP_HOLD;
                else
                    cell_op[i] = take_dn ? OP_TAKE_DN : OP_HOLD;
            end
        end

        sis_cell #(.PosW(PosW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (cell_op[i]),
            .dn_valid (dn_valid),
            .dn_key   (dn_key),
            .dn_pos   (dn_pos),
            .up_valid (up_valid),
            .up_key   (up_key),
            .up_pos   (up_pos),
            .valid    (cell_valid[i]),
            .key      (cell_key[i]),
            .pos      (cell_pos[i])
        );
    end

    // result from the bottom cell
    if (PosW >= POSITION_W)
    begin : g_pos_trunc
        assign m_tdata = {2'b00, cell_pos[0][POSITION_W-1:0]};
    end
    else
    begin : g_pos_ext
        assign m_tdata = 8'(cell_pos[0]);
    end

    assign m_tlast    = !cell_valid[1];
    assign m_tuser[0] = ovf_reg;

endmodule
